// File: rtl/brle_pkg.sv
package brle_pkg;

	localparam int MAX_LITERAL = 32;
	localparam int MAX_REPEAT  = 129;

	localparam int BYTE_W     = 8;
	localparam int RUN_W      = 8;
	localparam int LIT_CNT_W  = $clog2(MAX_LITERAL + 1);
	localparam int LIT_ADDR_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

	localparam logic [LIT_CNT_W-1:0] LIT_FULL = LIT_CNT_W'(MAX_LITERAL);
	localparam logic [RUN_W-1:0]     RUN_FULL = RUN_W'(MAX_REPEAT);
	localparam logic [RUN_W-1:0]     RUN_MIN  = RUN_W'(2);
	localparam logic [BYTE_W-1:0]    LIT_HDR_MARK = 8'h80;
	localparam logic [BYTE_W-1:0]    HDR_LEN_MASK = 8'h7f;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// front operations, handled lowest index first
	localparam int NUM_OPS = 7;
	localparam int OP_F1   = 0;  // flush literals before a run starts
	localparam int OP_R1   = 1;  // run finished by this byte
	localparam int OP_W1   = 2;  // held byte goes to the literal store
	localparam int OP_F1B  = 3;  // literal store just filled
	localparam int OP_R2   = 4;  // run closed by end of stream
	localparam int OP_W2   = 5;  // held byte stored at end of stream
	localparam int OP_FE   = 6;  // final literal flush at end of stream
	localparam logic [NUM_OPS-1:0] PUSH_MASK  = 7'b1011011;
	localparam logic [NUM_OPS-1:0] WRITE_MASK = 7'b0100100;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              last_of_burst;
	} out_item_t;

	typedef enum logic {
		CMD_RUN,
		CMD_LIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [BYTE_W-1:0]     hdr;
		logic [BYTE_W-1:0]     data;
		logic [LIT_CNT_W-1:0]  cnt;
		logic                  last;
	} cmd_t;

	typedef struct packed {
		logic idle;
	} back_stat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_HDR,
		B_RUNB,
		B_RD,
		B_LITB
	} back_state_t;

	function automatic logic [BYTE_W-1:0] lit_hdr(input logic [LIT_CNT_W-1:0] cnt);
		logic [BYTE_W-1:0] m;
		m = BYTE_W'(cnt) - 8'd1;
		return LIT_HDR_MARK | (m & HDR_LEN_MASK);
	endfunction

	function automatic logic [BYTE_W-1:0] run_hdr(input logic [RUN_W-1:0] len);
		return (len - RUN_MIN) & HDR_LEN_MASK;
	endfunction

endpackage

// File: rtl/brle_ram.sv
module brle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/brle_front.sv
module brle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  brle_pkg::in_item_t            item,
	output logic                          cmd_push,
	output brle_pkg::cmd_t                cmd,
	input  logic                          cmd_full,
	input  logic                          cmd_empty,
	input  brle_pkg::back_stat_t          back_stat,
	output logic                          ram_we,
	output logic [brle_pkg::LIT_ADDR_W-1:0] ram_waddr,
	output logic [brle_pkg::BYTE_W-1:0]   ram_wdata
);
	import brle_pkg::*;

	// encoder state
	logic [BYTE_W-1:0]    h_q, h_d;
	logic                 hv_q, hv_d;
	logic [RUN_W-1:0]     rl_q, rl_d;
	logic [LIT_CNT_W-1:0] c_q, c_d;
	logic [NUM_OPS-1:0]   pend_q, pend_d;

	// operands of the pending operations
	logic [LIT_CNT_W-1:0]  f1_cnt_q, fe_cnt_q;
	logic [BYTE_W-1:0]     r1_hdr_q, r1_byte_q, r2_hdr_q, r2_byte_q;
	logic [LIT_ADDR_W-1:0] w1_addr_q, w2_addr_q;
	logic [BYTE_W-1:0]     w1_data_q, w2_data_q;

	logic                 accept;
	logic                 eq;
	logic [NUM_OPS-1:0]   plan;
	logic [BYTE_W-1:0]    h1;
	logic                 hv1;
	logic [RUN_W-1:0]     rl1, rl_inc, r1_len;
	logic [LIT_CNT_W-1:0] c1, c2;

	logic [NUM_OPS-1:0]   cur;
	logic                 is_write;
	logic                 go;
	logic                 later_push;

	assign full   = |pend_q;
	assign accept = push && !full;

	// plan the whole request at once so the last result is known up front
	always_comb begin
		eq     = hv_q && (item.data_byte == h_q);
		plan   = '0;
		h1     = h_q;
		hv1    = hv_q;
		rl1    = rl_q;
		c1     = c_q;
		r1_len = rl_q;
		rl_inc = rl_q + 8'd1;
		if (!hv_q) begin
			h1  = item.data_byte;
			hv1 = 1'b1;
			rl1 = 8'd1;
		end else if (eq) begin
			if (rl_q < RUN_MIN) begin
				plan[OP_F1] = (c_q != '0);
				c1 = '0;
			end
			rl1 = rl_inc;
			if (rl_inc >= RUN_FULL) begin
				plan[OP_R1] = 1'b1;
				r1_len = rl_inc;
				hv1 = 1'b0;
				rl1 = '0;
			end
		end else begin
			if (rl_q >= RUN_MIN) begin
				plan[OP_R1] = 1'b1;
			end else begin
				plan[OP_W1] = 1'b1;
				c1 = c_q + LIT_CNT_W'(1);
				if (c1 >= LIT_FULL) begin
					plan[OP_F1B] = 1'b1;
					c1 = '0;
				end
			end
			h1  = item.data_byte;
			rl1 = 8'd1;
		end

		c2   = c1;
		h_d  = h1;
		hv_d = hv1;
		rl_d = rl1;
		c_d  = c1;
		if (item.end_of_stream) begin
			if (hv1) begin
				if (rl1 >= RUN_MIN) begin
					plan[OP_R2] = 1'b1;
				end else begin
					plan[OP_W2] = 1'b1;
					c2 = c1 + LIT_CNT_W'(1);
				end
			end
			plan[OP_FE] = (c2 != '0);
			h_d  = '0;
			hv_d = 1'b0;
			rl_d = '0;
			c_d  = '0;
		end
	end

	// step through the planned operations, one per cycle while the command queue and store allow
	always_comb begin
		cur        = pend_q & (~pend_q + NUM_OPS'(1));
		is_write   = |(cur & WRITE_MASK);
		later_push = |(pend_q & ~cur & PUSH_MASK);
		if (pend_q == '0) begin
			go = 1'b0;
		end else if (is_write) begin
			// the store must not change while a flush may still read it
			go = cmd_empty && back_stat.idle;
		end else begin
			go = !cmd_full;
		end

		cmd      = '0;
		cmd.last = !later_push;
		if (cur[OP_F1]) begin
			cmd.kind = CMD_LIT;
			cmd.hdr  = lit_hdr(f1_cnt_q);
			cmd.cnt  = f1_cnt_q;
		end else if (cur[OP_R1]) begin
			cmd.kind = CMD_RUN;
			cmd.hdr  = r1_hdr_q;
			cmd.data = r1_byte_q;
		end else if (cur[OP_F1B]) begin
			cmd.kind = CMD_LIT;
			cmd.hdr  = lit_hdr(LIT_FULL);
			cmd.cnt  = LIT_FULL;
		end else if (cur[OP_R2]) begin
			cmd.kind = CMD_RUN;
			cmd.hdr  = r2_hdr_q;
			cmd.data = r2_byte_q;
		end else begin
			cmd.kind = CMD_LIT;
			cmd.hdr  = lit_hdr(fe_cnt_q);
			cmd.cnt  = fe_cnt_q;
		end

		cmd_push  = go && !is_write;
		ram_we    = go && is_write;
		ram_waddr = cur[OP_W1] ? w1_addr_q : w2_addr_q;
		ram_wdata = cur[OP_W1] ? w1_data_q : w2_data_q;

		if (accept) begin
			pend_d = plan;
		end else if (go) begin
			pend_d = pend_q & ~cur;
		end else begin
			pend_d = pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= '0;
			hv_q   <= 1'b0;
			rl_q   <= '0;
			c_q    <= '0;
			pend_q <= '0;
		end else begin
			pend_q <= pend_d;
			if (accept) begin
				h_q  <= h_d;
				hv_q <= hv_d;
				rl_q <= rl_d;
				c_q  <= c_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f1_cnt_q  <= c_q;
			r1_hdr_q  <= run_hdr(r1_len);
			r1_byte_q <= h_q;
			w1_addr_q <= c_q[LIT_ADDR_W-1:0];
			w1_data_q <= h_q;
			r2_hdr_q  <= run_hdr(rl1);
			r2_byte_q <= h1;
			w2_addr_q <= c1[LIT_ADDR_W-1:0];
			w2_data_q <= h1;
			fe_cnt_q  <= c2;
		end
	end

	a_cnt_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		c_q < LIT_FULL)
		else $error("literal count reached the store size");

	a_no_hold_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		!hv_q |-> (rl_q == '0))
		else $error("run length set with nothing held");

	a_run_no_literals: assert property (@(posedge clk) disable iff (!arst_n)
		(hv_q && rl_q >= RUN_MIN) |-> (c_q == '0 && rl_q < RUN_FULL))
		else $error("run active with literals pending or run too long");

endmodule

// File: rtl/brle_cmd_fifo.sv
module brle_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brle_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output brle_pkg::cmd_t rdata,
	output logic           empty
);
	import brle_pkg::*;

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_push, do_pop;

	localparam logic [CMDQ_PTR_W-1:0] PTR_LAST = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
	localparam logic [CMDQ_CNT_W-1:0] CNT_FULL = CMDQ_CNT_W'(CMDQ_DEPTH);

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CMDQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CMDQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

endmodule

// File: rtl/brle_back.sv
module brle_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  brle_pkg::cmd_t                  cmd,
	input  logic                            cmd_empty,
	output logic                            cmd_pop,
	output logic                            ram_re,
	output logic [brle_pkg::LIT_ADDR_W-1:0] ram_raddr,
	input  logic [brle_pkg::BYTE_W-1:0]     ram_rdata,
	output brle_pkg::back_stat_t            stat,
	output logic                            empty,
	input  logic                            pop,
	output brle_pkg::out_item_t             result
);
	import brle_pkg::*;

	back_state_t          state_q, state_d;
	cmd_t                 cmd_q;
	logic [LIT_CNT_W-1:0] idx_q, idx_d;
	out_item_t            out_q, out_d;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 load;
	logic                 lit_end;

	assign out_free = !out_valid_q || pop;
	assign lit_end  = ((idx_q + LIT_CNT_W'(1)) == cmd_q.cnt);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd_pop = 1'b0;
		ram_re  = 1'b0;
		load    = 1'b0;
		out_d   = '0;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_d = B_HDR;
				end
			end
			B_HDR: begin
				if (out_free) begin
					load            = 1'b1;
					out_d.code_byte = cmd_q.hdr;
					idx_d           = '0;
					state_d         = (cmd_q.kind == CMD_RUN) ? B_RUNB : B_RD;
				end
			end
			B_RUNB: begin
				if (out_free) begin
					load                = 1'b1;
					out_d.code_byte     = cmd_q.data;
					out_d.last_of_burst = cmd_q.last;
					state_d             = B_IDLE;
				end
			end
			B_RD: begin
				ram_re  = 1'b1;
				state_d = B_LITB;
			end
			B_LITB: begin
				if (out_free) begin
					load                = 1'b1;
					out_d.code_byte     = ram_rdata;
					out_d.last_of_burst = cmd_q.last && lit_end;
					if (lit_end) begin
						state_d = B_IDLE;
					end else begin
						idx_d   = idx_q + LIT_CNT_W'(1);
						state_d = B_RD;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign ram_raddr = idx_q[LIT_ADDR_W-1:0];
	assign stat.idle = (state_q == B_IDLE);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (load) begin
			out_q <= out_d;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_LITB || state_q == B_RD) |-> (idx_q < cmd_q.cnt))
		else $error("literal index past the flush count");

endmodule

// File: rtl/byte_run_length_encoder.sv
// byte run-length encoder, packbits style
// input queue side: push an item (data_byte, end_of_stream) when full is low.
// result queue side: while empty is low the oldest code byte is on result;
// pop takes it. last_of_burst marks the final code byte caused by one request.
// a run of 2..129 equal bytes gives a header (length - 2) and the byte; up to
// 32 other bytes give a header (0x80 | count - 1) and the bytes themselves.
// the front takes a new request straight away when the last one only updated the
// held byte or run length; when it stores a literal or queues a code, full stays
// high while the planned steps are done in order, one step per cycle unless stalled.
// storing a literal waits until the command queue is empty and the back is
// idle, since queued literal codes still read the one literal memory.
// the back sends a run code as its header then the byte, and n literals as the
// header then each literal, each literal costing one memory read and one output load.
// first result reaches the ports once its command has passed the command queue and the
// back's idle and header states, later when a literal store comes first or the back is busy.
// reset empties the held byte, run and literal counts, the command queue and
// the output register; the literal memory needs no clearing.
// when pop stays low the output register holds, the back stops, the command
// queue fills and full rises; nothing is dropped.
module byte_run_length_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  brle_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output brle_pkg::out_item_t result
);
	import brle_pkg::*;

	cmd_t                  f_cmd, q_cmd;
	logic                  f_cmd_push;
	logic                  q_full, q_empty, q_pop;
	back_stat_t            b_stat;
	logic                  ram_we, ram_re;
	logic [LIT_ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

	brle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_push  (f_cmd_push),
		.cmd       (f_cmd),
		.cmd_full  (q_full),
		.cmd_empty (q_empty),
		.back_stat (b_stat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	brle_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_cmd_push),
		.wdata  (f_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty)
	);

	brle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.stat      (b_stat),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	brle_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_LITERAL),
		.AW    (LIT_ADDR_W)
	) u_lit_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
